// ===== hw/rtl/scab_pkg.sv =====
package scab_pkg;

	localparam int DIM_W   = 12;
	localparam int FRAME_W = 8;
	localparam int FIDX_W  = 10;
	localparam int TICK_W  = 17;
	localparam int DELAY_W = 16;
	localparam int MODE_W  = 2;
	localparam int KIND_W  = 2;
	localparam int COLOR_W = 8;
	localparam int TEX_W   = 24;
	localparam int SCR_W   = 22;
	localparam int APB_AW  = 5;
	localparam int APB_DW  = 32;
	localparam int REG_IDX_W = 3;

	localparam logic [DIM_W-1:0]   MAX_DIM      = 12'd2048;
	localparam logic [COLOR_W-1:0] ALPHA_OPAQUE = 8'hFF;
	localparam logic [COLOR_W-1:0] ALPHA_CLEAR  = 8'h00;

	// request kinds
	localparam logic [KIND_W-1:0] KIND_BLIT    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PIXEL   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_SCREEN_WIDTH   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_SCREEN_HEIGHT  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_TEXTURE_STRIDE = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_CELL_WIDTH     = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_CELL_HEIGHT    = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_FRAME_TOTAL    = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_TICK_DELAY     = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_ANIM_MODE      = 3'd7;

	localparam logic [DIM_W-1:0]   RST_SCREEN_WIDTH   = 12'd640;
	localparam logic [DIM_W-1:0]   RST_SCREEN_HEIGHT  = 12'd480;
	localparam logic [DIM_W-1:0]   RST_TEXTURE_STRIDE = 12'd64;
	localparam logic [DIM_W-1:0]   RST_CELL_WIDTH     = 12'd64;
	localparam logic [DIM_W-1:0]   RST_CELL_HEIGHT    = 12'd64;
	localparam logic [FRAME_W-1:0] RST_FRAME_TOTAL    = 8'd0;
	localparam logic [DELAY_W-1:0] RST_TICK_DELAY     = 16'd0;
	localparam logic [MODE_W-1:0]  RST_ANIM_MODE      = 2'd3;

	typedef struct packed {
		logic [DIM_W-1:0]   screen_width;
		logic [DIM_W-1:0]   screen_height;
		logic [DIM_W-1:0]   texture_stride;
		logic [DIM_W-1:0]   cell_width;
		logic [DIM_W-1:0]   cell_height;
		logic [FRAME_W-1:0] frame_total;
		logic [DELAY_W-1:0] tick_delay;
		logic [MODE_W-1:0]  anim_mode;
	} cfg_t;

	typedef struct packed {
		logic               shown;
		logic [FRAME_W-1:0] frame;
		logic               visible;
	} anim_stat_t;

	typedef struct packed {
		logic               shown;
		logic [FRAME_W-1:0] frame_now;
		logic [TEX_W-1:0]   tex_start;
		logic [SCR_W-1:0]   screen_start;
		logic [DIM_W-1:0]   run_width;
		logic [DIM_W-1:0]   run_height;
	} blit_res_t;

	typedef struct packed {
		logic               write_rgb;
		logic               write_alpha;
		logic [COLOR_W-1:0] out_red;
		logic [COLOR_W-1:0] out_green;
		logic [COLOR_W-1:0] out_blue;
		logic [COLOR_W-1:0] out_alpha;
	} pix_res_t;

	function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
		return (v > MAX_DIM) ? MAX_DIM : v;
	endfunction

endpackage

// ===== hw/rtl/scab_if.sv =====
interface scab_item_if;
	import scab_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [KIND_W-1:0]         kind;
	logic signed [DIM_W-1:0]   pos_x;
	logic signed [DIM_W-1:0]   pos_y;
	logic [COLOR_W-1:0]        src_red;
	logic [COLOR_W-1:0]        src_green;
	logic [COLOR_W-1:0]        src_blue;
	logic [COLOR_W-1:0]        src_alpha;
	logic [COLOR_W-1:0]        dst_red;
	logic [COLOR_W-1:0]        dst_green;
	logic [COLOR_W-1:0]        dst_blue;

	modport source (
		output valid, kind, pos_x, pos_y, src_red, src_green, src_blue, src_alpha,
		output dst_red, dst_green, dst_blue,
		input  ready
	);
	modport sink (
		input  valid, kind, pos_x, pos_y, src_red, src_green, src_blue, src_alpha,
		input  dst_red, dst_green, dst_blue,
		output ready
	);
endinterface

interface scab_result_if;
	import scab_pkg::*;

	logic               valid;
	logic               ready;
	logic               shown;
	logic [FRAME_W-1:0] frame_now;
	logic [TEX_W-1:0]   tex_start;
	logic [SCR_W-1:0]   screen_start;
	logic [DIM_W-1:0]   run_width;
	logic [DIM_W-1:0]   run_height;
	logic               write_rgb;
	logic               write_alpha;
	logic [COLOR_W-1:0] out_red;
	logic [COLOR_W-1:0] out_green;
	logic [COLOR_W-1:0] out_blue;
	logic [COLOR_W-1:0] out_alpha;

	modport source (
		output valid, shown, frame_now, tex_start, screen_start, run_width, run_height,
		output write_rgb, write_alpha, out_red, out_green, out_blue, out_alpha,
		input  ready
	);
	modport sink (
		input  valid, shown, frame_now, tex_start, screen_start, run_width, run_height,
		input  write_rgb, write_alpha, out_red, out_green, out_blue, out_alpha,
		output ready
	);
endinterface

// ===== hw/rtl/scab_regs.sv =====
module scab_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [scab_pkg::APB_AW-1:0]  paddr,
	input  logic [scab_pkg::APB_DW-1:0]  pwdata,
	output logic [scab_pkg::APB_DW-1:0]  prdata,
	output logic                         pready,
	output scab_pkg::cfg_t               cfg
);
	import scab_pkg::*;

	logic [REG_IDX_W-1:0] idx;
	logic                 wr_en;
	cfg_t                 cfg_q;

	assign idx    = paddr[APB_AW-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width   <= RST_SCREEN_WIDTH;
			cfg_q.screen_height  <= RST_SCREEN_HEIGHT;
			cfg_q.texture_stride <= RST_TEXTURE_STRIDE;
			cfg_q.cell_width     <= RST_CELL_WIDTH;
			cfg_q.cell_height    <= RST_CELL_HEIGHT;
			cfg_q.frame_total    <= RST_FRAME_TOTAL;
			cfg_q.tick_delay     <= RST_TICK_DELAY;
			cfg_q.anim_mode      <= RST_ANIM_MODE;
		end else if (wr_en) begin
			unique case (idx)
				REG_SCREEN_WIDTH:   cfg_q.screen_width   <= pwdata[DIM_W-1:0];
				REG_SCREEN_HEIGHT:  cfg_q.screen_height  <= pwdata[DIM_W-1:0];
				REG_TEXTURE_STRIDE: cfg_q.texture_stride <= pwdata[DIM_W-1:0];
				REG_CELL_WIDTH:     cfg_q.cell_width     <= pwdata[DIM_W-1:0];
				REG_CELL_HEIGHT:    cfg_q.cell_height    <= pwdata[DIM_W-1:0];
				REG_FRAME_TOTAL:    cfg_q.frame_total    <= pwdata[FRAME_W-1:0];
				REG_TICK_DELAY:     cfg_q.tick_delay     <= pwdata[DELAY_W-1:0];
				REG_ANIM_MODE:      cfg_q.anim_mode      <= pwdata[MODE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_SCREEN_WIDTH:   prdata = APB_DW'(cfg_q.screen_width);
			REG_SCREEN_HEIGHT:  prdata = APB_DW'(cfg_q.screen_height);
			REG_TEXTURE_STRIDE: prdata = APB_DW'(cfg_q.texture_stride);
			REG_CELL_WIDTH:     prdata = APB_DW'(cfg_q.cell_width);
			REG_CELL_HEIGHT:    prdata = APB_DW'(cfg_q.cell_height);
			REG_FRAME_TOTAL:    prdata = APB_DW'(cfg_q.frame_total);
			REG_TICK_DELAY:     prdata = APB_DW'(cfg_q.tick_delay);
			REG_ANIM_MODE:      prdata = APB_DW'(cfg_q.anim_mode);
			default:            prdata = '0;
		endcase
	end

endmodule

// ===== hw/rtl/scab_anim.sv =====
module scab_anim (
	input  logic                 clk,
	input  logic                 arst_n,
	input  scab_pkg::cfg_t       cfg,
	input  logic                 step_blit,
	input  logic                 step_restart,
	output scab_pkg::anim_stat_t stat
);
	import scab_pkg::*;

	logic signed [FIDX_W-1:0] frame_q;
	logic [TICK_W-1:0]        tick_q;
	logic                     vis_q;

	logic                     fwd;
	logic                     loop_en;
	logic                     active;
	logic                     step;
	logic [TICK_W-1:0]        tick_inc;
	logic [TICK_W-1:0]        tick_nx;
	logic signed [FIDX_W-1:0] frame_step;
	logic signed [FIDX_W-1:0] frame_last;
	logic signed [FIDX_W-1:0] frame_nx;
	logic                     vis_nx;

	assign fwd     = cfg.anim_mode[0];
	assign loop_en = cfg.anim_mode[1];
	assign active  = vis_q && (cfg.frame_total != '0);

	always_comb begin
		tick_inc   = tick_q + 1'b1;
		step       = tick_inc > TICK_W'(cfg.tick_delay);
		tick_nx    = step ? '0 : tick_inc;
		frame_last = $signed(FIDX_W'(cfg.frame_total)) - FIDX_W'(1);
		frame_step = frame_q;
		if (step) begin
			frame_step = fwd ? frame_q + FIDX_W'(1) : frame_q - FIDX_W'(1);
		end
		frame_nx = frame_step;
		vis_nx   = vis_q;
		if (fwd) begin
			if (frame_step > frame_last) begin
				if (loop_en) frame_nx = '0;
				else vis_nx = 1'b0;
			end
		end else if (frame_step[FIDX_W-1]) begin
			if (loop_en) frame_nx = frame_last;
			else vis_nx = 1'b0;
		end
	end

	assign stat.visible = vis_q;
	assign stat.shown   = active ? vis_nx : vis_q;
	assign stat.frame   = active ? frame_nx[FRAME_W-1:0] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
			tick_q  <= '0;
			vis_q   <= 1'b1;
		end else if (step_restart) begin
			// rewind; keep tick count
			frame_q <= '0;
			vis_q   <= 1'b1;
		end else if (step_blit && active) begin
			frame_q <= frame_nx;
			tick_q  <= tick_nx;
			vis_q   <= vis_nx;
		end
	end

endmodule

// ===== hw/rtl/scab_clip.sv =====
module scab_clip (
	input  scab_pkg::cfg_t                cfg,
	input  logic signed [scab_pkg::DIM_W-1:0] pos_x,
	input  logic signed [scab_pkg::DIM_W-1:0] pos_y,
	input  scab_pkg::anim_stat_t          stat,
	output scab_pkg::blit_res_t           res
);
	import scab_pkg::*;

	localparam int CW = DIM_W + 2;

	logic [DIM_W-1:0]        sw, sh, cw, ch;
	logic signed [CW-1:0]    px, py;
	logic signed [CW-1:0]    left, top, span_x, span_y, right, bottom, rw, rh;
	logic                    fit;
	logic [DIM_W-2:0]        px_c, py_c;
	logic [2*DIM_W-1:0]      tex_row;
	logic [FRAME_W+DIM_W-1:0] tex_cell;
	logic [TEX_W-1:0]        tex_sum;
	logic [2*DIM_W-1:0]      scr_row;
	logic [2*DIM_W-1:0]      scr_sum;

	always_comb begin
		sw = sat_dim(cfg.screen_width);
		sh = sat_dim(cfg.screen_height);
		cw = sat_dim(cfg.cell_width);
		ch = sat_dim(cfg.cell_height);
		px = CW'(pos_x);
		py = CW'(pos_y);

		// trim the cell rectangle to the screen
		left   = px[CW-1] ? -px : '0;
		top    = py[CW-1] ? -py : '0;
		span_x = $signed(CW'(sw)) - px;
		span_y = $signed(CW'(sh)) - py;
		right  = (span_x < $signed(CW'(cw))) ? span_x : $signed(CW'(cw));
		bottom = (span_y < $signed(CW'(ch))) ? span_y : $signed(CW'(ch));
		rw     = right - left;
		rh     = bottom - top;
		fit    = (rw > 0) && (rh > 0);

		px_c = pos_x[DIM_W-1] ? '0 : pos_x[DIM_W-2:0];
		py_c = pos_y[DIM_W-1] ? '0 : pos_y[DIM_W-2:0];

		tex_row  = (2*DIM_W)'(top[DIM_W-1:0]) * (2*DIM_W)'(cfg.texture_stride);
		tex_cell = (FRAME_W+DIM_W)'(stat.frame) * (FRAME_W+DIM_W)'(cw);
		tex_sum  = TEX_W'(tex_row) + TEX_W'(left[DIM_W-1:0]) + TEX_W'(tex_cell);
		scr_row  = (2*DIM_W)'(py_c) * (2*DIM_W)'(sw);
		scr_sum  = scr_row + (2*DIM_W)'(px_c);

		res = '0;
		if (stat.shown) begin
			res.shown     = 1'b1;
			res.frame_now = stat.frame;
			if (fit) begin
				res.tex_start    = tex_sum;
				res.screen_start = scr_sum[SCR_W-1:0];
				res.run_width    = rw[DIM_W-1:0];
				res.run_height   = rh[DIM_W-1:0];
			end
		end
	end

endmodule

// ===== hw/rtl/scab_blend.sv =====
module scab_blend (
	input  logic [scab_pkg::COLOR_W-1:0] src_red,
	input  logic [scab_pkg::COLOR_W-1:0] src_green,
	input  logic [scab_pkg::COLOR_W-1:0] src_blue,
	input  logic [scab_pkg::COLOR_W-1:0] src_alpha,
	input  logic [scab_pkg::COLOR_W-1:0] dst_red,
	input  logic [scab_pkg::COLOR_W-1:0] dst_green,
	input  logic [scab_pkg::COLOR_W-1:0] dst_blue,
	output scab_pkg::pix_res_t           res
);
	import scab_pkg::*;

	// d + floor(a*(s-d)/256), wrapped to a byte
	function automatic logic [COLOR_W-1:0] mix(
		input logic [COLOR_W-1:0] a,
		input logic [COLOR_W-1:0] s,
		input logic [COLOR_W-1:0] d
	);
		logic signed [COLOR_W:0]       diff;
		logic signed [2*COLOR_W+1:0]   prod;
		diff = $signed({1'b0, s}) - $signed({1'b0, d});
		prod = $signed({1'b0, a}) * diff;
		return d + prod[2*COLOR_W-1:COLOR_W];
	endfunction

	always_comb begin
		res = '0;
		if (src_alpha == ALPHA_CLEAR) begin
			res.out_red   = dst_red;
			res.out_green = dst_green;
			res.out_blue  = dst_blue;
		end else if (src_alpha == ALPHA_OPAQUE) begin
			res.write_rgb   = 1'b1;
			res.write_alpha = 1'b1;
			res.out_red     = src_red;
			res.out_green   = src_green;
			res.out_blue    = src_blue;
			res.out_alpha   = ALPHA_OPAQUE;
		end else begin
			res.write_rgb = 1'b1;
			res.out_red   = mix(src_alpha, src_red, dst_red);
			res.out_green = mix(src_alpha, src_green, dst_green);
			res.out_blue  = mix(src_alpha, src_blue, dst_blue);
		end
	end

endmodule

// ===== hw/rtl/sprite_clip_alpha_blitter_core.sv =====
// Sprite blitter front end. Requests arrive on the item channel and carry one
// of three kinds: a blit command (advances the sprite animation, then clips the
// current frame, placed at signed pos_x/pos_y, to the screen and reports the
// visibility, frame, texture and screen start addresses in pixels and the
// clipped run size), a pixel blend (source RGBA over destination RGB: alpha 0
// writes nothing, alpha 255 copies all four bytes, otherwise
// d + floor(a*(s-d)/256) on each color byte), or a restart (rewinds the frame
// and makes the sprite visible again; no result). Blit and pixel requests each
// give exactly one result; result fields of the other kind read zero. The
// block takes one request per clock unless the result stalls: a request is
// registered, worked through combinational logic (the longest path is the
// 12x12 texture row multiply and its address add, behind the animation step
// for blits) and lands in an output register once that register is free or
// being drained. While a result stalls, a request still enters an empty
// input register, but the item channel stalls once that register is full.
// The eight configuration registers sit on the APB port at byte
// addresses 4*i and must be written only while no request is in flight.
module sprite_clip_alpha_blitter_core (
	input  logic                         clk,
	input  logic                         arst_n,
	scab_item_if.sink                    item,
	scab_result_if.source                result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [scab_pkg::APB_AW-1:0]  paddr,
	input  logic [scab_pkg::APB_DW-1:0]  pwdata,
	output logic [scab_pkg::APB_DW-1:0]  prdata,
	output logic                         pready
);
	import scab_pkg::*;

	cfg_t       cfg;
	anim_stat_t anim_stat;
	blit_res_t  blit_res;
	pix_res_t   pix_res;

	// input register
	logic                    valid_s1;
	logic [KIND_W-1:0]       kind_s1;
	logic signed [DIM_W-1:0] pos_x_s1;
	logic signed [DIM_W-1:0] pos_y_s1;
	logic [COLOR_W-1:0]      src_red_s1, src_green_s1, src_blue_s1, src_alpha_s1;
	logic [COLOR_W-1:0]      dst_red_s1, dst_green_s1, dst_blue_s1;

	// result register
	logic       res_valid_s2;
	blit_res_t  blit_s2;
	pix_res_t   pix_s2;

	logic take;
	logic adv_s1;
	logic is_blit;
	logic is_pixel;
	logic is_restart;
	logic emit;
	logic step_blit;
	logic step_restart;

	scab_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// advance stage 1 whenever the result register is free or being drained
	assign adv_s1     = valid_s1 && (!res_valid_s2 || result.ready);
	assign item.ready = !valid_s1 || adv_s1;
	assign take       = item.valid && item.ready;

	assign is_blit    = (kind_s1 == KIND_BLIT);
	assign is_pixel   = (kind_s1 == KIND_PIXEL);
	assign is_restart = (kind_s1 == KIND_RESTART);

	// restart and unknown requests retire without a result
	assign emit         = adv_s1 && (is_blit || is_pixel);
	assign step_blit    = adv_s1 && is_blit;
	assign step_restart = adv_s1 && is_restart;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// hold the request payload until it advances
	always_ff @(posedge clk) begin
		if (take) begin
			kind_s1      <= item.kind;
			pos_x_s1     <= item.pos_x;
			pos_y_s1     <= item.pos_y;
			src_red_s1   <= item.src_red;
			src_green_s1 <= item.src_green;
			src_blue_s1  <= item.src_blue;
			src_alpha_s1 <= item.src_alpha;
			dst_red_s1   <= item.dst_red;
			dst_green_s1 <= item.dst_green;
			dst_blue_s1  <= item.dst_blue;
		end
	end

	scab_anim u_anim (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.step_blit    (step_blit),
		.step_restart (step_restart),
		.stat         (anim_stat)
	);

	scab_clip u_clip (
		.cfg   (cfg),
		.pos_x (pos_x_s1),
		.pos_y (pos_y_s1),
		.stat  (anim_stat),
		.res   (blit_res)
	);

	scab_blend u_blend (
		.src_red   (src_red_s1),
		.src_green (src_green_s1),
		.src_blue  (src_blue_s1),
		.src_alpha (src_alpha_s1),
		.dst_red   (dst_red_s1),
		.dst_green (dst_green_s1),
		.dst_blue  (dst_blue_s1),
		.res       (pix_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			res_valid_s2 <= emit;
		end else if (result.ready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	// zero the fields that belong to the other kind
	always_ff @(posedge clk) begin
		if (emit) begin
			blit_s2 <= is_blit ? blit_res : '0;
			pix_s2  <= is_pixel ? pix_res : '0;
		end
	end

	assign result.valid        = res_valid_s2;
	assign result.shown        = blit_s2.shown;
	assign result.frame_now    = blit_s2.frame_now;
	assign result.tex_start    = blit_s2.tex_start;
	assign result.screen_start = blit_s2.screen_start;
	assign result.run_width    = blit_s2.run_width;
	assign result.run_height   = blit_s2.run_height;
	assign result.write_rgb    = pix_s2.write_rgb;
	assign result.write_alpha  = pix_s2.write_alpha;
	assign result.out_red      = pix_s2.out_red;
	assign result.out_green    = pix_s2.out_green;
	assign result.out_blue     = pix_s2.out_blue;
	assign result.out_alpha    = pix_s2.out_alpha;

`ifndef SYNTH
	ap_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && !item.ready |-> valid_s1 && res_valid_s2 && !result.ready)
		else $error("input stalled with free pipeline space");

	ap_alpha_only_on_copy: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.write_alpha |->
		result.write_rgb && result.out_alpha == ALPHA_OPAQUE)
		else $error("alpha write without opaque copy");

	ap_kinds_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.write_rgb |-> !result.shown && result.run_width == '0)
		else $error("pixel result carries blit fields");

	ap_run_needs_shown: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.run_width != '0 |-> result.shown && result.run_height != '0)
		else $error("run size on hidden or empty blit");

	ap_visible_by_restart: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(anim_stat.visible) |-> $past(step_restart))
		else $error("sprite became visible without restart");
`endif

endmodule

// ===== test/tb_top.sv =====
module tb_top;
	import scab_pkg::*;

	// Kind value the block must swallow without a result.
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	// Saturation point of the screen and cell dimensions.
	localparam int DIM_CAP = 2048;

	// Requests per settings phase in the random part, and the phase count.
	localparam int PHASE_REQS = 60;
	localparam int PHASES     = 24;

	// Cycles to let pass once nothing is expected: covers the input and
	// result registers plus a restart that leaves no result behind.
	localparam int SETTLE_CYCLES = 6;

	// Cycles without any handshake before the run is declared hung.
	localparam int IDLE_LIMIT = 2000;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [DIM_W-1:0]   pos_x;
		logic [DIM_W-1:0]   pos_y;
		logic [COLOR_W-1:0] src_red;
		logic [COLOR_W-1:0] src_green;
		logic [COLOR_W-1:0] src_blue;
		logic [COLOR_W-1:0] src_alpha;
		logic [COLOR_W-1:0] dst_red;
		logic [COLOR_W-1:0] dst_green;
		logic [COLOR_W-1:0] dst_blue;
	} sprite_req_t;

	typedef struct packed {
		blit_res_t blit;
		pix_res_t  pix;
	} blit_pixel_res_t;

	// Receiver stall patterns.
	typedef enum logic [1:0] {
		RX_OPEN,   // always ready
		RX_COIN,   // ready on a coin flip
		RX_COMB,   // stalls in a repeating comb pattern
		RX_BLOCKY  // long stalls now and then
	} rx_pattern_t;

	logic clk = 1'b0;
	logic arst_n;

	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [APB_AW-1:0]   paddr;
	logic [APB_DW-1:0]   pwdata;
	logic [APB_DW-1:0]   prdata;
	logic                pready;

	scab_item_if   req_ch ();
	scab_result_if res_ch ();

	sprite_clip_alpha_blitter_core DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (req_ch.sink),
		.result  (res_ch.source),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Requests waiting for the driver, and blit/pixel results still owed.
	sprite_req_t     reqs_to_send[$];
	blit_pixel_res_t results_due[$];

	// Shadow of the register file and of the sprite animation state.
	cfg_t cfg_now;
	int   frame_idx;
	int   tick_cnt;
	bit   sprite_visible;

	// Handshake flags of the current rising edge; the request driver reads
	// req_taken at the following falling edge.
	bit req_taken;
	bit res_taken;

	int error_count;
	int idle_cycles;
	int n_blits, n_hidden, n_clipped, n_pixels, n_opaque, n_clear, n_restarts;
	int n_frame_events, n_unused;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic int capped(input logic [DIM_W-1:0] v);
		return (int'(v) > DIM_CAP) ? DIM_CAP : int'(v);
	endfunction

	// Step the animation, then clip the current frame rectangle placed at
	// (x, y) against the screen. A hidden sprite leaves every field at zero.
	function automatic blit_pixel_res_t blit_result(input logic [DIM_W-1:0] x_raw,
			input logic [DIM_W-1:0] y_raw);
		blit_pixel_res_t r;
		int     px, py, sw, sh, cw, ch, total, frame;
		int     left, top, right, bottom, rw, rh;
		longint tex, scr;
		bit     fwd, looping;

		r       = '0;
		px      = int'($signed(x_raw));
		py      = int'($signed(y_raw));
		sw      = capped(cfg_now.screen_width);
		sh      = capped(cfg_now.screen_height);
		cw      = capped(cfg_now.cell_width);
		ch      = capped(cfg_now.cell_height);
		total   = int'(cfg_now.frame_total);
		frame   = 0;
		fwd     = cfg_now.anim_mode[0];
		looping = cfg_now.anim_mode[1];

		if (!sprite_visible)
			return r;
		if (total >= 1) begin
			// tick counter is 17 bits wide; step once it passes the delay
			tick_cnt = (tick_cnt + 1) & 'h1FFFF;
			if (tick_cnt > int'(cfg_now.tick_delay)) begin
				tick_cnt  = 0;
				frame_idx = frame_idx + (fwd ? 1 : -1);
			end
			if (fwd ? (frame_idx > total - 1) : (frame_idx < 0)) begin
				n_frame_events++;
				if (!looping)
					sprite_visible = 1'b0;
				else if (fwd)
					frame_idx = 0;
				else
					frame_idx = total - 1;
			end
			if (!sprite_visible)
				return r;
			frame = frame_idx;
		end

		left   = (px < 0) ? -px : 0;
		top    = (py < 0) ? -py : 0;
		right  = (sw - px < cw) ? sw - px : cw;
		bottom = (sh - py < ch) ? sh - py : ch;
		rw     = right - left;
		rh     = bottom - top;

		r.blit.shown     = 1'b1;
		r.blit.frame_now = frame[FRAME_W-1:0];
		if (rw > 0 && rh > 0) begin
			tex = longint'(top) * longint'(cfg_now.texture_stride) + longint'(left)
				+ longint'(frame & 'h3FF) * longint'(cw);
			scr = longint'((py < 0) ? 0 : py) * longint'(sw) + longint'((px < 0) ? 0 : px);
			r.blit.tex_start    = tex[TEX_W-1:0];
			r.blit.screen_start = scr[SCR_W-1:0];
			r.blit.run_width    = rw[DIM_W-1:0];
			r.blit.run_height   = rh[DIM_W-1:0];
		end
		return r;
	endfunction

	// d + floor(a * (s - d) / 256); the arithmetic shift floors negatives.
	function automatic logic [COLOR_W-1:0] mix_byte(input int a, input int s, input int d);
		int prod;
		prod = a * (s - d);
		return COLOR_W'(d + (prod >>> 8));
	endfunction

	function automatic blit_pixel_res_t pixel_result(input sprite_req_t q);
		blit_pixel_res_t r;
		r = '0;
		if (q.src_alpha == ALPHA_CLEAR) begin
			r.pix.out_red   = q.dst_red;
			r.pix.out_green = q.dst_green;
			r.pix.out_blue  = q.dst_blue;
		end else if (q.src_alpha == ALPHA_OPAQUE) begin
			r.pix.write_rgb   = 1'b1;
			r.pix.write_alpha = 1'b1;
			r.pix.out_red     = q.src_red;
			r.pix.out_green   = q.src_green;
			r.pix.out_blue    = q.src_blue;
			r.pix.out_alpha   = q.src_alpha;
		end else begin
			r.pix.write_rgb = 1'b1;
			r.pix.out_red   = mix_byte(q.src_alpha, q.src_red, q.dst_red);
			r.pix.out_green = mix_byte(q.src_alpha, q.src_green, q.dst_green);
			r.pix.out_blue  = mix_byte(q.src_alpha, q.src_blue, q.dst_blue);
		end
		return r;
	endfunction

	task automatic cmp_field(input string fname, input longint got, input longint want);
		if (got != want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
			error_count++;
		end
	endtask

	// ------------------------------------------------------------------
	// Request generation
	// ------------------------------------------------------------------

	function automatic logic [COLOR_W-1:0] pick_byte();
		case ($urandom_range(4, 0))
			0:       return 8'd0;
			1:       return 8'd255;
			default: return COLOR_W'($urandom_range(255, 0));
		endcase
	endfunction

	function automatic logic [COLOR_W-1:0] pick_alpha();
		case ($urandom_range(9, 0))
			0, 1:    return ALPHA_CLEAR;
			2, 3:    return ALPHA_OPAQUE;
			4:       return 8'd1;
			5:       return 8'd254;
			default: return COLOR_W'($urandom_range(255, 0));
		endcase
	endfunction

	// Mostly sizes from 1 to typ_hi pixels, now and then 1, the cap, or
	// a value past the cap that must saturate.
	function automatic int unsigned pick_dim(input int unsigned typ_hi);
		case ($urandom_range(9, 0))
			0:       return 1;
			1:       return DIM_CAP;
			2:       return $urandom_range(4095, DIM_CAP + 1);
			default: return $urandom_range(typ_hi, 1);
		endcase
	endfunction

	// Fill the payload of the other kind with noise; the block must ignore it.
	function automatic sprite_req_t noisy_req(input logic [KIND_W-1:0] kind);
		sprite_req_t q;
		q.kind      = kind;
		q.pos_x     = DIM_W'($urandom);
		q.pos_y     = DIM_W'($urandom);
		q.src_red   = COLOR_W'($urandom);
		q.src_green = COLOR_W'($urandom);
		q.src_blue  = COLOR_W'($urandom);
		q.src_alpha = COLOR_W'($urandom);
		q.dst_red   = COLOR_W'($urandom);
		q.dst_green = COLOR_W'($urandom);
		q.dst_blue  = COLOR_W'($urandom);
		return q;
	endfunction

	task automatic queue_blit(input int x, input int y);
		sprite_req_t q;
		q       = noisy_req(KIND_BLIT);
		q.pos_x = x[DIM_W-1:0];
		q.pos_y = y[DIM_W-1:0];
		reqs_to_send.push_back(q);
	endtask

	task automatic queue_pixel(input int sr, input int sg, input int sb, input int sa,
			input int dr, input int dg, input int db);
		sprite_req_t q;
		q           = noisy_req(KIND_PIXEL);
		q.src_red   = sr[COLOR_W-1:0];
		q.src_green = sg[COLOR_W-1:0];
		q.src_blue  = sb[COLOR_W-1:0];
		q.src_alpha = sa[COLOR_W-1:0];
		q.dst_red   = dr[COLOR_W-1:0];
		q.dst_green = dg[COLOR_W-1:0];
		q.dst_blue  = db[COLOR_W-1:0];
		reqs_to_send.push_back(q);
	endtask

	// Pick a position that mostly lands on or near the screen, so that
	// partial clips on every side are common; otherwise anywhere.
	function automatic int pick_pos(input int screen_dim, input int cell_dim);
		int p;
		if ($urandom_range(4, 0) == 0)
			return int'($signed(DIM_W'($urandom)));
		p = int'($urandom_range(screen_dim + cell_dim + 16, 0)) - cell_dim - 8;
		if (p < -2048)
			p = -2048;
		if (p > 2047)
			p = 2047;
		return p;
	endfunction

	// ------------------------------------------------------------------
	// Configuration port
	// ------------------------------------------------------------------

	// Run one APB write: setup cycle, then access cycle. The register takes
	// the value at the rising edge inside the access cycle; update the shadow
	// copy right after, while nothing is in flight.
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int unsigned value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_SCREEN_WIDTH:   cfg_now.screen_width   = value[DIM_W-1:0];
			REG_SCREEN_HEIGHT:  cfg_now.screen_height  = value[DIM_W-1:0];
			REG_TEXTURE_STRIDE: cfg_now.texture_stride = value[DIM_W-1:0];
			REG_CELL_WIDTH:     cfg_now.cell_width     = value[DIM_W-1:0];
			REG_CELL_HEIGHT:    cfg_now.cell_height    = value[DIM_W-1:0];
			REG_FRAME_TOTAL:    cfg_now.frame_total    = value[FRAME_W-1:0];
			REG_TICK_DELAY:     cfg_now.tick_delay     = value[DELAY_W-1:0];
			REG_ANIM_MODE:      cfg_now.anim_mode      = value[MODE_W-1:0];
			default: ;
		endcase
	endtask

	// Hold until every queued request is sent and every owed result is back,
	// then let the pipeline settle so a trailing restart is done too.
	task automatic wait_drained();
		while (reqs_to_send.size() != 0 || req_ch.valid || results_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Request driver: bursts of random length with random gaps between them
	// ------------------------------------------------------------------

	int burst_left = 1;
	int gap_left   = 0;

	always @(negedge clk) begin : req_driver
		sprite_req_t q;
		// advance only once the request on the bus has been taken
		if (arst_n && (!req_ch.valid || req_taken)) begin
			if (gap_left > 0 || reqs_to_send.size() == 0) begin
				if (gap_left > 0)
					gap_left--;
				req_ch.valid <= 1'b0;
			end else begin
				q = reqs_to_send.pop_front();
				req_ch.valid     <= 1'b1;
				req_ch.kind      <= q.kind;
				req_ch.pos_x     <= q.pos_x;
				req_ch.pos_y     <= q.pos_y;
				req_ch.src_red   <= q.src_red;
				req_ch.src_green <= q.src_green;
				req_ch.src_blue  <= q.src_blue;
				req_ch.src_alpha <= q.src_alpha;
				req_ch.dst_red   <= q.dst_red;
				req_ch.dst_green <= q.dst_green;
				req_ch.dst_blue  <= q.dst_blue;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					// new burst; about a third of them follow with no gap
					burst_left = $urandom_range(24, 1);
					gap_left   = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(8, 1);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result receiver: stall patterns that change after a random count of cycles
	// ------------------------------------------------------------------

	rx_pattern_t rx_pattern = RX_OPEN;
	int          rx_left    = 40;
	int          rx_comb    = 0;
	int          rx_hold    = 0;

	always @(negedge clk) begin : res_receiver
		if (rx_left == 0) begin
			rx_pattern = rx_pattern_t'($urandom_range(3, 0));
			rx_left    = $urandom_range(150, 30);
		end else begin
			rx_left--;
		end
		case (rx_pattern)
			RX_OPEN: res_ch.ready <= 1'b1;
			RX_COIN: res_ch.ready <= 1'($urandom_range(1, 0));
			RX_COMB: begin
				rx_comb = (rx_comb + 1) % 5;
				res_ch.ready <= (rx_comb >= 2);
			end
			default: begin
				if (rx_hold > 0) begin
					rx_hold--;
					res_ch.ready <= 1'b0;
				end else begin
					res_ch.ready <= 1'b1;
					if ($urandom_range(3, 0) == 0)
						rx_hold = $urandom_range(12, 1);
				end
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Monitor: predict on every taken request, check every taken result,
	// and watch for a hang
	// ------------------------------------------------------------------

	always @(posedge clk) begin : monitor
		sprite_req_t     q;
		blit_pixel_res_t got;
		blit_pixel_res_t want;
		bit              apb_write;

		req_taken = arst_n && req_ch.valid && req_ch.ready;
		res_taken = arst_n && res_ch.valid && res_ch.ready;
		apb_write = arst_n && psel && penable && pwrite && pready;

		if (req_taken) begin
			q.kind      = req_ch.kind;
			q.pos_x     = req_ch.pos_x;
			q.pos_y     = req_ch.pos_y;
			q.src_red   = req_ch.src_red;
			q.src_green = req_ch.src_green;
			q.src_blue  = req_ch.src_blue;
			q.src_alpha = req_ch.src_alpha;
			q.dst_red   = req_ch.dst_red;
			q.dst_green = req_ch.dst_green;
			q.dst_blue  = req_ch.dst_blue;
			case (q.kind)
				KIND_BLIT: begin
					want = blit_result(q.pos_x, q.pos_y);
					results_due.push_back(want);
					n_blits++;
					if (!want.blit.shown)
						n_hidden++;
					else if (want.blit.run_width == '0)
						n_clipped++;
				end
				KIND_PIXEL: begin
					results_due.push_back(pixel_result(q));
					n_pixels++;
					if (q.src_alpha == ALPHA_OPAQUE)
						n_opaque++;
					if (q.src_alpha == ALPHA_CLEAR)
						n_clear++;
				end
				KIND_RESTART: begin
					// rewind and show again; the tick count carries over
					frame_idx      = 0;
					sprite_visible = 1'b1;
					n_restarts++;
				end
				default: n_unused++;
			endcase
		end

		if (res_taken) begin
			got.blit.shown        = res_ch.shown;
			got.blit.frame_now    = res_ch.frame_now;
			got.blit.tex_start    = res_ch.tex_start;
			got.blit.screen_start = res_ch.screen_start;
			got.blit.run_width    = res_ch.run_width;
			got.blit.run_height   = res_ch.run_height;
			got.pix.write_rgb     = res_ch.write_rgb;
			got.pix.write_alpha   = res_ch.write_alpha;
			got.pix.out_red       = res_ch.out_red;
			got.pix.out_green     = res_ch.out_green;
			got.pix.out_blue      = res_ch.out_blue;
			got.pix.out_alpha     = res_ch.out_alpha;
			if (results_due.size() == 0) begin
				$display("%0t: result with none expected, expected nothing, actual %h",
					$time, got);
				error_count++;
			end else begin
				want = results_due.pop_front();
				cmp_field("shown",        got.blit.shown,        want.blit.shown);
				cmp_field("frame_now",    got.blit.frame_now,    want.blit.frame_now);
				cmp_field("tex_start",    got.blit.tex_start,    want.blit.tex_start);
				cmp_field("screen_start", got.blit.screen_start, want.blit.screen_start);
				cmp_field("run_width",    got.blit.run_width,    want.blit.run_width);
				cmp_field("run_height",   got.blit.run_height,   want.blit.run_height);
				cmp_field("write_rgb",    got.pix.write_rgb,     want.pix.write_rgb);
				cmp_field("write_alpha",  got.pix.write_alpha,   want.pix.write_alpha);
				cmp_field("out_red",      got.pix.out_red,       want.pix.out_red);
				cmp_field("out_green",    got.pix.out_green,     want.pix.out_green);
				cmp_field("out_blue",     got.pix.out_blue,      want.pix.out_blue);
				cmp_field("out_alpha",    got.pix.out_alpha,     want.pix.out_alpha);
			end
		end

		// Count cycles in which nothing moves on any port; drop out if the
		// block stops answering.
		if (!arst_n || req_taken || res_taken || apb_write)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: watchdog: no handshake for %0d cycles, %0d results owed",
				$time, idle_cycles, results_due.size());
			$display("tb: failure");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin : sequencer
		int unsigned setting [8];
		int          sent;
		int          sw_eff, sh_eff, cw_eff, ch_eff;
		int          roll;

		// Drive every input to a known value before the first edge.
		arst_n           = 1'b0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		req_ch.valid     = 1'b0;
		req_ch.kind      = KIND_BLIT;
		req_ch.pos_x     = '0;
		req_ch.pos_y     = '0;
		req_ch.src_red   = '0;
		req_ch.src_green = '0;
		req_ch.src_blue  = '0;
		req_ch.src_alpha = '0;
		req_ch.dst_red   = '0;
		req_ch.dst_green = '0;
		req_ch.dst_blue  = '0;
		res_ch.ready     = 1'b0;

		// Shadow state as it comes out of reset.
		cfg_now.screen_width   = 12'd640;
		cfg_now.screen_height  = 12'd480;
		cfg_now.texture_stride = 12'd64;
		cfg_now.cell_width     = 12'd64;
		cfg_now.cell_height    = 12'd64;
		cfg_now.frame_total    = 8'd0;
		cfg_now.tick_delay     = 16'd0;
		cfg_now.anim_mode      = 2'd3;
		frame_idx      = 0;
		tick_cnt       = 0;
		sprite_visible = 1'b1;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed requests on the reset settings (static 64x64 sprite on a
		// 640x480 screen): corners, full and partial clips, exact fits.
		queue_blit(0, 0);
		queue_blit(-2048, -2048);
		queue_blit(2047, 2047);
		queue_blit(-10, -5);
		queue_blit(600, 450);
		queue_blit(-64, 10);
		queue_blit(640, 0);
		queue_blit(576, 416);
		queue_blit(-1, -1);
		// Blends: no write, opaque copy, the smallest and largest partial
		// alphas, rounding of a negative difference, equal bytes.
		queue_pixel(255, 255, 255, 0, 0, 0, 0);
		queue_pixel(0, 0, 0, 255, 255, 255, 255);
		queue_pixel(255, 128, 1, 1, 0, 127, 254);
		queue_pixel(0, 255, 7, 254, 255, 0, 200);
		queue_pixel(255, 0, 128, 128, 0, 255, 128);
		queue_pixel(0, 0, 0, 128, 255, 255, 255);
		queue_pixel(99, 200, 13, 200, 99, 200, 13);
		reqs_to_send.push_back(noisy_req(KIND_RESTART));
		reqs_to_send.push_back(noisy_req(KIND_UNUSED));
		queue_blit(5, 5);

		for (int phase = 0; phase < PHASES; phase++) begin
			wait_drained();

			// The first phases pin the extremes and walk the animation into
			// its corner cases; the rest pick settings at random.
			case (phase)
				0: setting = '{4095, 4095, 4095, 4095, 4095, 255, 65535, 3};
				1: setting = '{1, 1, 1, 1, 1, 1, 0, 0};
				// let the frame run up high, then shrink the frame count so
				// backward stepping starts from an out-of-range frame
				2: setting = '{320, 240, 512, 32, 32, 200, 0, 3};
				3: setting = '{320, 240, 512, 32, 32, 5, 1, 2};
				4: setting = '{2048, 2048, 4095, 2048, 2048, 4, 0, 1};
				default: begin
					setting[REG_SCREEN_WIDTH]   = pick_dim(800);
					setting[REG_SCREEN_HEIGHT]  = pick_dim(600);
					setting[REG_TEXTURE_STRIDE] = ($urandom_range(4, 0) == 0)
						? 4095 : $urandom_range(1024, 1);
					setting[REG_CELL_WIDTH]     = pick_dim(128);
					setting[REG_CELL_HEIGHT]    = pick_dim(128);
					roll = $urandom_range(9, 0);
					setting[REG_FRAME_TOTAL]    = (roll < 3) ? 0
						: (roll < 8) ? $urandom_range(8, 1)
						: (roll == 8) ? $urandom_range(254, 9) : 255;
					roll = $urandom_range(9, 0);
					setting[REG_TICK_DELAY]     = (roll < 5) ? $urandom_range(3, 0)
						: (roll < 8) ? $urandom_range(20, 4)
						: (roll == 8) ? 65535 : $urandom_range(65535, 0);
					setting[REG_ANIM_MODE]      = $urandom_range(3, 0);
				end
			endcase
			for (int i = 0; i < 8; i++)
				write_reg(REG_IDX_W'(i), setting[i]);

			sw_eff = capped(cfg_now.screen_width);
			sh_eff = capped(cfg_now.screen_height);
			cw_eff = capped(cfg_now.cell_width);
			ch_eff = capped(cfg_now.cell_height);

			// Mostly blits at positions around the screen and pixel blends;
			// restarts revive a sprite that ran out of frames, and the unused
			// kind shows up as noise on top of the counted requests.
			sent = 0;
			while (sent < PHASE_REQS) begin
				roll = $urandom_range(99, 0);
				if (roll < 50) begin
					queue_blit(pick_pos(sw_eff, cw_eff), pick_pos(sh_eff, ch_eff));
				end else if (roll < 88) begin
					queue_pixel(pick_byte(), pick_byte(), pick_byte(), pick_alpha(),
						pick_byte(), pick_byte(), pick_byte());
				end else if (roll < 96) begin
					reqs_to_send.push_back(noisy_req(KIND_RESTART));
				end else begin
					reqs_to_send.push_back(noisy_req(KIND_UNUSED));
					continue;
				end
				sent++;
			end
		end

		wait_drained();

		$display("run: %0d blits (%0d hidden, %0d clipped away), %0d frame wraps or ends",
			n_blits, n_hidden, n_clipped, n_frame_events);
		$display("run: %0d blends (%0d opaque, %0d clear), %0d restarts, %0d ignored, %0d phases",
			n_pixels, n_opaque, n_clear, n_restarts, n_unused, PHASES);
		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/scab_pkg.sv
hw/rtl/scab_if.sv
hw/rtl/scab_regs.sv
hw/rtl/scab_anim.sv
hw/rtl/scab_clip.sv
hw/rtl/scab_blend.sv
hw/rtl/sprite_clip_alpha_blitter_core.sv
test/tb_top.sv
